// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the sorted insert block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define SUI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define SUI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/sui_pkg.sv =====
// Package for the sorted unique insert block: request codes, status codes,
// field widths and the output request struct. No dependencies.
`default_nettype none

package sui_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [6:0] MAX_RESULTS = 7'd32;

  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd2;

  localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_PRESENT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  position;
    logic              last;
    logic [STAT_W-1:0] status;
  } out_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/sui_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled. No dependencies.
`default_nettype none

module sui_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/sui_outreg.sv =====
// Output register of the sorted insert block: holds one result request
// until the master side takes it. Depends on sui_pkg.
`default_nettype none

module sui_outreg
  import sui_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire out_req_t               req_i,
  output logic                        free_o,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,  // value_out[31:0], position[36:32]
  output logic                        m_axis_tlast_o,
  output logic [STAT_W-1:0]           m_axis_tuser_o   // status[1:0]
);

  logic     valid_q, valid_d;
  out_req_t req_q;

  assign free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      req_q <= req_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {3'b000, req_q.position, req_q.value};
  assign m_axis_tlast_o  = req_q.last;
  assign m_axis_tuser_o  = req_q.status;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_unique_insert.sv =====
// Top level of the sorted unique insert block: list controller around one
// entry RAM. Depends on sui_pkg, sui_ram and sui_outreg.
//
//   Channel  Dir  Sideband      Payload
//   s_axis   in   tuser: func   tdata: value[31:0]
//   m_axis   out  tuser: status tdata: value_out[31:0], position[36:32]; tlast: last
//
// Clear and append requests complete in the idle state. An insert request
// with n entries in the list starts the RAM read, searches the list one
// entry at a time, then streams the list out one entry at a time, n entries
// (n + 1 when the value goes in), writing each shifted entry back through
// the same RAM pass. Output stalls pause the stream pass.
// Reset empties the list at once; the entry RAM has no reset.
`default_nettype none

module sorted_unique_insert
  import sui_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [VAL_W-1:0]       s_axis_tdata_i,  // value[31:0]
  input  wire logic [FUNC_W-1:0]      s_axis_tuser_i,  // func[1:0]
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,  // value_out[31:0], position[36:32]
  output logic                        m_axis_tlast_o,
  output logic [STAT_W-1:0]           m_axis_tuser_o   // status[1:0]
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     total_q, total_d;
  logic              ins_q, ins_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [VAL_W-1:0]  hold_q, hold_d;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [VAL_W-1:0]  wdata, rdata;
  logic signed [VAL_W-1:0] rd_s;
  logic [VAL_W-1:0]  emit_val;
  logic [CW-1:0]     idx_nx;
  logic              in_accept, in_range, out_free, out_load;
  out_req_t          out_req;

  sui_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sui_outreg u_outreg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (out_load),
    .req_i           (out_req),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_s            = $signed(rdata);
  assign idx_nx          = idx_q + ONE_C;
  assign in_range        = (7'(idx_q) < MAX_RESULTS);

  always_comb begin
    if (!ins_q || (idx_q < pos_q)) begin
      emit_val = rdata;
    end else if (idx_q == pos_q) begin
      emit_val = val_q;
    end else begin
      emit_val = hold_q;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    total_d  = total_q;
    ins_d    = ins_q;
    stat_d   = stat_q;
    val_d    = val_q;
    hold_d   = hold_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = s_axis_tdata_i;
    re       = 1'b0;
    raddr    = '0;
    out_load = 1'b0;
    out_req  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (s_axis_tuser_i)
            FN_CLEAR: begin
              cnt_d = '0;
            end
            FN_APPEND: begin
              if (cnt_q < DEPTH_C) begin
                we    = 1'b1;
                waddr = cnt_q[AW-1:0];
                cnt_d = cnt_q + ONE_C;
              end
            end
            FN_INSERT: begin
              val_d = $signed(s_axis_tdata_i);
              re    = 1'b1;
              idx_d = '0;
              if (cnt_q == '0) begin
                ins_d   = 1'b1;
                stat_d  = STAT_INSERTED;
                pos_d   = '0;
                total_d = ONE_C;
                state_d = S_EMIT;
              end else begin
                state_d = S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SRCH: begin
        if (rd_s == val_q) begin
          ins_d   = 1'b0;
          stat_d  = STAT_PRESENT;
          total_d = cnt_q;
          re      = 1'b1;
          idx_d   = '0;
          state_d = S_EMIT;
        end else if ((rd_s > val_q) || (idx_q == cnt_q - ONE_C)) begin
          if (cnt_q == DEPTH_C) begin
            ins_d   = 1'b0;
            stat_d  = STAT_FULL;
            total_d = cnt_q;
          end else begin
            ins_d   = 1'b1;
            stat_d  = STAT_INSERTED;
            pos_d   = (rd_s > val_q) ? idx_q : cnt_q;
            total_d = cnt_q + ONE_C;
          end
          re      = 1'b1;
          idx_d   = '0;
          state_d = S_EMIT;
        end else begin
          re    = 1'b1;
          raddr = idx_nx[AW-1:0];
          idx_d = idx_nx;
        end
      end

      S_EMIT: begin
        if (!in_range || out_free) begin
          out_load         = in_range;
          out_req.value    = emit_val;
          out_req.position = POS_W'(idx_q);
          out_req.last     = (idx_nx == total_q) || (7'(idx_q) == MAX_RESULTS - 7'd1);
          out_req.status   = stat_q;
          if (ins_q && (idx_q >= pos_q)) begin
            we     = 1'b1;
            waddr  = idx_q[AW-1:0];
            wdata  = emit_val;
            hold_d = rdata;
          end
          if (idx_nx == total_q) begin
            cnt_d   = total_q;
            state_d = S_IDLE;
          end else begin
            re    = 1'b1;
            raddr = idx_nx[AW-1:0];
            idx_d = idx_nx;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      pos_q   <= '0;
      total_q <= '0;
      ins_q   <= 1'b0;
      stat_q  <= STAT_INSERTED;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      total_q <= total_d;
      ins_q   <= ins_d;
      stat_q  <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    hold_q <= hold_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/sui_checker.sv =====
// Port-level checker for the sorted insert block, bound to the top level.
// Depends on sui_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sui_checker
  import sui_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tready_o,
  input wire logic                   m_axis_tvalid_o,
  input wire logic                   m_axis_tready_i,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // value_out[31:0], position[36:32]
  input wire logic                   m_axis_tlast_o,
  input wire logic [STAT_W-1:0]      m_axis_tuser_o   // status[1:0]
);

  logic              run_open_q;
  logic [STAT_W-1:0] run_stat_q;
  logic              out_take;

  assign out_take = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q <= 1'b0;
      run_stat_q <= STAT_INSERTED;
    end else if (out_take) begin
      run_open_q <= !m_axis_tlast_o;
      run_stat_q <= m_axis_tuser_o;
    end
  end

  `SUI_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped while stalled")
  `SUI_ASSERT(a_no_take_mid_run, clk_i, rst_ni, run_open_q && !(m_axis_tvalid_o && m_axis_tlast_o) |-> !s_axis_tready_o, "request taken during a list run")
  `SUI_ASSERT(a_first_pos_zero, clk_i, rst_ni, m_axis_tvalid_o && !run_open_q |-> m_axis_tdata_o[36:32] == 5'd0, "run does not start at position zero")
  `SUI_ASSERT(a_run_status, clk_i, rst_ni, m_axis_tvalid_o && run_open_q |-> m_axis_tuser_o == run_stat_q, "status changed within a run")
  `SUI_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid_o, "result shown during reset")

endmodule

bind sorted_unique_insert sui_checker u_sui_checker (.*);

`default_nettype wire
